// ===== sv/fvn_pkg.sv =====
// ============================================================================
// fvn_pkg
// Shared widths, hash constants, link type and blend helper for the 3D
// fractal value-noise pipeline.
// ============================================================================
`default_nettype none

package fvn_pkg;

  // Field widths
  localparam int POS_W   = 18;
  localparam int FREQ_W  = 24;
  localparam int HS_W    = 24;
  localparam int OC_W    = 4;
  localparam int SEED_W  = 64;
  localparam int OUT_W   = 25;

  // Position times frequency, signed
  localparam int M_W     = POS_W + FREQ_W;
  // Weighted octave sum, signed
  localparam int SUM_W   = 35;
  // Corner / blended noise value, signed Q16 in [-1,1]
  localparam int NV_W    = 18;
  // Fade weight, unsigned Q1.16 in [0,1]
  localparam int W_W     = 17;
  // Register stages in one octave cell
  localparam int CELL_LAT = 12;

  // Coordinate multipliers of the corner hash, x / y / z
  localparam logic [63:0] AXIS_MUL [3] = '{
    64'h9e3779b97f4a7c15,
    64'hbf58476d1ce4e5b9,
    64'h94d049bb133111eb
  };
  // Finalizer multipliers
  localparam logic [63:0] MIX_MUL [2] = '{
    64'hff51afd7ed558ccd,
    64'hc4ceb9fe1a85ec53
  };
  // Per-octave seed salt
  localparam logic [63:0] OCT_SALT = 64'hD1B54A32D192ED03;
  // 0.1 in Q0.20
  localparam logic signed [17:0] TENTH_Q20 = 18'sd104858;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SEED   = 3'd0,
    REG_STREAM = 3'd1,
    REG_FREQ   = 3'd2,
    REG_OCT    = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_t;

  // Data handed from one octave cell to the next
  typedef struct packed {
    logic [2:0][M_W-1:0]     m;    // pos * frequency per axis, signed
    logic signed [SUM_W-1:0] sum;  // weighted octave sum so far
  } fvn_link_t;

  // Linear blend a + floor((b - a) * w / 65536)
  function automatic logic signed [NV_W-1:0] lerp(
    input logic signed [NV_W-1:0] a,
    input logic signed [NV_W-1:0] b,
    input logic [W_W-1:0]         w
  );
    logic signed [NV_W:0]   d;
    logic signed [W_W:0]    ws;
    logic signed [36:0]     p;
    logic signed [20:0]     r;
    d  = (NV_W+1)'(b) - (NV_W+1)'(a);
    ws = $signed({1'b0, w});
    p  = d * ws;
    r  = 21'(a) + 21'(p >>> 16);
    return r[NV_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/fvn_cell.sv =====
// ============================================================================
// fvn_cell
// One octave of value noise: lattice split, corner hashes, fade weights,
// trilinear blend and accumulation into the running sum, 12 stages.
// ============================================================================
`default_nettype none

module fvn_cell
  import fvn_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  fvn_link_t       in_link,
  input  logic            octave_on,
  input  logic [63:0]     base_seed,
  output logic            out_valid,
  output fvn_link_t       out_link
);

  localparam int SHIFT     = 2 + IDX;
  localparam int ACC_SHIFT = 15 - IDX;
  localparam logic [63:0] SALT = 64'(IDX + 1) * OCT_SALT;

  // Valid bits and passthrough line
  logic [CELL_LAT:1] vq;
  fvn_link_t         pass_q [1:CELL_LAT-1];
  logic [2:0][W_W-1:0] wl [3:10];

  // Stage registers
  logic [2:0][63:0] s1_pl;
  logic [2:0][31:0] s1_ph;
  logic [2:0]       s1_neg;
  logic [2:0][15:0] s1_t, s1_t2;
  logic [2:0][63:0] s2_k0;
  logic [2:0][15:0] s2_t3;
  logic [2:0][20:0] s2_poly;
  logic [63:0]      s3_h  [8];
  logic [63:0]      s4_p0 [8];
  logic [31:0]      s4_p1 [8];
  logic [31:0]      s4_p2 [8];
  logic [63:0]      s5_h  [8];
  logic [63:0]      s6_p0 [8];
  logic [31:0]      s6_p1 [8];
  logic [31:0]      s6_p2 [8];
  logic [15:0]      s7_h16 [8];
  logic signed [NV_W-1:0] s8_v [8];
  logic signed [NV_W-1:0] s9_r [4];
  logic signed [NV_W-1:0] s10_q [2];
  logic signed [NV_W-1:0] s11_n;
  fvn_link_t        o_link;

  // Next values
  logic [2:0][63:0] s1_pl_next;
  logic [2:0][31:0] s1_ph_next;
  logic [2:0]       s1_neg_next;
  logic [2:0][15:0] s1_t_next, s1_t2_next;
  logic [2:0][63:0] s2_k0_next;
  logic [2:0][15:0] s2_t3_next;
  logic [2:0][20:0] s2_poly_next;
  logic [2:0][W_W-1:0] w_next;
  logic [63:0]      s3_h_next  [8];
  logic [63:0]      s4_p0_next [8];
  logic [31:0]      s4_p1_next [8];
  logic [31:0]      s4_p2_next [8];
  logic [63:0]      s5_h_next  [8];
  logic [63:0]      s6_p0_next [8];
  logic [31:0]      s6_p1_next [8];
  logic [31:0]      s6_p2_next [8];
  logic [15:0]      s7_h16_next [8];
  logic signed [NV_W-1:0] s8_v_next [8];
  fvn_link_t        o_link_next;

  // Stage 1: scale to this octave, split lattice index and fraction
  always_comb begin
    logic signed [63:0] c;
    logic [31:0]        li;
    for (int a = 0; a < 3; a++) begin
      c = 64'($signed(in_link.m[a])) <<< SHIFT;
      li = c[63:32];
      s1_pl_next[a]  = 64'(li) * 64'(AXIS_MUL[a][31:0]);
      s1_ph_next[a]  = li * AXIS_MUL[a][63:32];
      s1_neg_next[a] = li[31];
      s1_t_next[a]   = c[31:16];
      s1_t2_next[a]  = 16'((32'(c[31:16]) * 32'(c[31:16])) >> 16);
    end
  end

  // Stage 2: finish index products, fade cube and polynomial
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s2_k0_next[a] = s1_pl[a] + {s1_ph[a], 32'b0}
                    - (s1_neg[a] ? {AXIS_MUL[a][31:0], 32'b0} : 64'b0);
      s2_t3_next[a] = 16'((32'(s1_t2[a]) * 32'(s1_t[a])) >> 16);
      s2_poly_next[a] = 21'(s1_t2[a]) * 21'd6 + 21'd655360
                      - 21'(s1_t[a]) * 21'd15;
    end
  end

  // Stage 3: fade weights, combine axis terms per corner, first shift-xor
  always_comb begin
    logic [2:0][63:0] k1;
    logic [63:0]      h;
    for (int a = 0; a < 3; a++) begin
      w_next[a] = W_W'((37'(s2_t3[a]) * 37'(s2_poly[a])) >> 16);
      k1[a]     = s2_k0[a] + AXIS_MUL[a];
    end
    for (int j = 0; j < 8; j++) begin
      h = base_seed ^ SALT
        ^ (((j & 1) != 0) ? k1[0] : s2_k0[0])
        ^ (((j & 2) != 0) ? k1[1] : s2_k0[1])
        ^ (((j & 4) != 0) ? k1[2] : s2_k0[2]);
      s3_h_next[j] = h ^ (h >> 33);
    end
  end

  // Stages 4 to 7: two multiply-xorshift rounds, products split in halves
  always_comb begin
    logic [63:0] h;
    for (int j = 0; j < 8; j++) begin
      s4_p0_next[j] = 64'(s3_h[j][31:0]) * 64'(MIX_MUL[0][31:0]);
      s4_p1_next[j] = s3_h[j][31:0] * MIX_MUL[0][63:32];
      s4_p2_next[j] = s3_h[j][63:32] * MIX_MUL[0][31:0];
      h = s4_p0[j] + {s4_p1[j] + s4_p2[j], 32'b0};
      s5_h_next[j] = h ^ (h >> 33);
      s6_p0_next[j] = 64'(s5_h[j][31:0]) * 64'(MIX_MUL[1][31:0]);
      s6_p1_next[j] = s5_h[j][31:0] * MIX_MUL[1][63:32];
      s6_p2_next[j] = s5_h[j][63:32] * MIX_MUL[1][31:0];
      h = s6_p0[j] + {s6_p1[j] + s6_p2[j], 32'b0};
      s7_h16_next[j] = h[15:0] ^ h[48:33];
    end
  end

  // Stage 8: map the 16-bit hash to [-1,1]
  always_comb begin
    logic [16:0] v;
    logic [17:0] q;
    for (int j = 0; j < 8; j++) begin
      v = {s7_h16[j], 1'b0};
      q = 18'(v) + ((v == 17'd131070) ? 18'd2 : ((v >= 17'd65535) ? 18'd1 : 18'd0));
      s8_v_next[j] = NV_W'($signed({1'b0, q}) - 19'sd65536);
    end
  end

  // Stage 12: add this octave into the sum
  always_comb begin
    o_link_next.m   = pass_q[CELL_LAT-1].m;
    o_link_next.sum = pass_q[CELL_LAT-1].sum
                    + (octave_on ? (SUM_W'(s11_n) <<< ACC_SHIFT) : SUM_W'(0));
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (en) begin
      vq <= {vq[CELL_LAT-1:1], in_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      pass_q[1] <= in_link;
      for (int s = 2; s < CELL_LAT; s++) pass_q[s] <= pass_q[s-1];
      wl[3] <= w_next;
      for (int s = 4; s <= 10; s++) wl[s] <= wl[s-1];
      s1_pl <= s1_pl_next;
      s1_ph <= s1_ph_next;
      s1_neg <= s1_neg_next;
      s1_t <= s1_t_next;
      s1_t2 <= s1_t2_next;
      s2_k0 <= s2_k0_next;
      s2_t3 <= s2_t3_next;
      s2_poly <= s2_poly_next;
      s3_h <= s3_h_next;
      s4_p0 <= s4_p0_next;
      s4_p1 <= s4_p1_next;
      s4_p2 <= s4_p2_next;
      s5_h <= s5_h_next;
      s6_p0 <= s6_p0_next;
      s6_p1 <= s6_p1_next;
      s6_p2 <= s6_p2_next;
      s7_h16 <= s7_h16_next;
      s8_v <= s8_v_next;
      // blend along x, then y, then z
      for (int k = 0; k < 4; k++) s9_r[k] <= lerp(s8_v[2*k], s8_v[2*k+1], wl[8][0]);
      s10_q[0] <= lerp(s9_r[0], s9_r[1], wl[9][1]);
      s10_q[1] <= lerp(s9_r[2], s9_r[3], wl[9][1]);
      s11_n <= lerp(s10_q[0], s10_q[1], wl[10][2]);
      o_link <= o_link_next;
    end
  end

  assign out_valid = vq[CELL_LAT];
  assign out_link  = o_link;

endmodule

`default_nettype wire

// ===== sv/fvn_norm.sv =====
// ============================================================================
// fvn_norm
// Normalize the octave sum by the amplitude total, apply 0.1 * elev_gain
// and saturate to the output range, 4 stages.
// ============================================================================
`default_nettype none

module fvn_norm
  import fvn_pkg::*;
#(
  parameter  int MAX_OCTAVES = 8,
  localparam int NW = $clog2(MAX_OCTAVES + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [SUM_W-1:0] in_sum,
  input  logic [NW-1:0]           n_eff,
  input  logic [HS_W-1:0]         elev_gain,
  output logic                    out_valid,
  output logic [OUT_W-1:0]        out_elev
);

  // Reciprocal of the amplitude total, Q1.30
  logic [30:0] rtab [0:MAX_OCTAVES];

  assign rtab[0] = '0;
  for (genvar k = 1; k <= MAX_OCTAVES; k++) begin : g_rtab
    localparam longint unsigned DEN = (64'd1 << k) - 64'd1;
    localparam longint unsigned RV  = ((64'd1 << (k + 29)) + DEN / 2) / DEN;
    assign rtab[k] = 31'(RV);
  end

  logic [4:1]          nv;
  logic signed [20:0]  d1;
  logic signed [45:0]  p2;
  logic signed [27:0]  r3;
  logic [OUT_W-1:0]    elev;

  logic signed [66:0]  prod1;
  logic signed [63:0]  prod3;
  logic [OUT_W-1:0]    elev_next;

  always_comb begin
    prod1 = in_sum * $signed({1'b0, rtab[n_eff]});
    prod3 = p2 * TENTH_Q20;
    // clamp to the 25-bit signed range
    if (r3 > 28'sd16777215) begin
      elev_next = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (r3 < -28'sd16777216) begin
      elev_next = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      elev_next = r3[OUT_W-1:0];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      nv <= '0;
    end else if (en) begin
      nv <= {nv[3:1], in_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      d1   <= 21'(prod1 >>> 45);
      p2   <= d1 * $signed({1'b0, elev_gain});
      r3   <= 28'(prod3 >>> 36);
      elev <= elev_next;
    end
  end

  assign out_valid = nv[4];
  assign out_elev  = elev;

endmodule

`default_nettype wire

// ===== sv/fractal_value_noise_3d_core.sv =====
// ============================================================================
// fractal_value_noise_3d_core
// Fractal 3D value noise: one point in, one scaled elevation out.
// ============================================================================
// Usage:
//   s_tdata carries one point (three signed Q1.16 coordinates); m_tdata
//   returns one signed Q8.16 elevation per point, in request order.
//   Configuration is written through cfg_we / cfg_addr / cfg_data while the
//   pipeline is empty; indexes beyond the register list are dropped.
// Throughput: one point per cycle while the output is not stalled.
// Pipeline: an input register, then the chain of octave cells, one
//   12-stage cell per octave, then the normalizer; unused
//   octaves pass their sum through unchanged, so latency does not depend on
//   octave_count.
// Stall: the whole pipeline freezes while m_tvalid is high and m_tready low;
//   s_tready is low exactly then, and the output register holds its data.
// Reset: rst clears all valid bits and loads seed 0, stream offset 0,
//   frequency 1.0, four octaves and height scale 1.0.
// ============================================================================
`default_nettype none

module fractal_value_noise_3d_core
  import fvn_pkg::*;
#(
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // pos_x [17:0], pos_y [35:18], pos_z [53:36]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // elevation_detail [24:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_data
);

  localparam int NW = $clog2(MAX_OCTAVES + 1);

  // Configuration registers
  logic [SEED_W-1:0] seed_value;
  logic [SEED_W-1:0] stream_key;
  logic [FREQ_W-1:0] frequency;
  logic [OC_W-1:0]   octave_count;
  logic [HS_W-1:0]   elev_gain;

  logic              en;
  logic [4:0]        n_eff5;
  logic [NW-1:0]     n_eff;
  logic [63:0]       base_seed;
  logic [MAX_OCTAVES-1:0] cell_on;

  logic              v0;
  fvn_link_t         link  [0:MAX_OCTAVES];
  logic              lvalid [0:MAX_OCTAVES];
  logic signed [POS_W+FREQ_W:0] mx, my, mz;
  fvn_link_t         link0_next;
  logic [OUT_W-1:0]  elev;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value    <= '0;
      stream_key    <= '0;
      frequency     <= FREQ_W'(65536);
      octave_count  <= OC_W'(4);
      elev_gain     <= HS_W'(65536);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_SEED:   seed_value    <= cfg_data;
        REG_STREAM: stream_key    <= cfg_data;
        REG_FREQ:   frequency     <= cfg_data[FREQ_W-1:0];
        REG_OCT:    octave_count  <= cfg_data[OC_W-1:0];
        REG_HEIGHT: elev_gain     <= cfg_data[HS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp octave count to [1, MAX_OCTAVES] and enable cells below it
  always_comb begin
    if (octave_count == '0) begin
      n_eff5 = 5'd1;
    end else if (5'(octave_count) > 5'(MAX_OCTAVES)) begin
      n_eff5 = 5'(MAX_OCTAVES);
    end else begin
      n_eff5 = 5'(octave_count);
    end
    for (int i = 0; i < MAX_OCTAVES; i++) cell_on[i] = 5'(i) < n_eff5;
  end

  assign n_eff     = NW'(n_eff5);
  assign base_seed = seed_value ^ stream_key;

  // Pipeline advances unless the output is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input stage: scale position by base frequency
  always_comb begin
    mx = $signed(s_tdata[17:0])  * $signed({1'b0, frequency});
    my = $signed(s_tdata[35:18]) * $signed({1'b0, frequency});
    mz = $signed(s_tdata[53:36]) * $signed({1'b0, frequency});
    link0_next.m[0] = mx[M_W-1:0];
    link0_next.m[1] = my[M_W-1:0];
    link0_next.m[2] = mz[M_W-1:0];
    link0_next.sum  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      link[0] <= link0_next;
    end
  end

  assign lvalid[0] = v0;

  // Chain of octave cells
  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
    fvn_cell #(
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (lvalid[g]),
      .in_link   (link[g]),
      .octave_on (cell_on[g]),
      .base_seed (base_seed),
      .out_valid (lvalid[g+1]),
      .out_link  (link[g+1])
    );
  end

  // Normalize, scale and saturate
  fvn_norm #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_norm (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (lvalid[MAX_OCTAVES]),
    .in_sum       (link[MAX_OCTAVES].sum),
    .n_eff        (n_eff),
    .elev_gain    (elev_gain),
    .out_valid    (m_tvalid),
    .out_elev     (elev)
  );

  assign m_tdata = {{(32-OUT_W){1'b0}}, elev};

  // Reset empties the output register
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

  // Clamped octave count stays in range
  assert property (@(posedge clk) disable iff (rst)
    (n_eff5 >= 5'd1) && (n_eff5 <= 5'(MAX_OCTAVES)))
    else $error("octave count clamp out of range");

  // Accepted request enters the first stage
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v0)
    else $error("accepted request lost at input stage");

  // Held output freezes the input stage
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(v0))
    else $error("input stage moved during stall");

endmodule

`default_nettype wire

// ===== verif/fractal_value_noise_3d_core_test.sv =====
// ============================================================================
// fractal_value_noise_3d_core_test
// Self-checking bench for the 3D fractal value-noise core: points stream in
// with random gaps and stalls, a local model predicts every elevation, and
// each returned elevation is checked in order across several register sets.
// ============================================================================
`timescale 1ns / 100ps

module fractal_value_noise_3d_core_test
  import fvn_pkg::*;
;

  localparam int          CORE_LATENCY = 101;
  localparam int          SETTLE       = CORE_LATENCY + 40;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          LONG_HOLD    = 400;
  localparam logic [2:0]  REG_SPARE_LO = 3'd5;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;
  localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;    // pos_x [17:0], pos_y [35:18], pos_z [53:36]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // elevation_detail [24:0]
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [63:0] cfg_data = '0;

  // Register copies used for prediction
  logic [63:0] seed_sh = '0;
  logic [63:0] stream_sh = '0;
  logic [23:0] freq_sh = 24'd65536;
  logic [3:0]  oct_sh = 4'd4;
  logic [23:0] height_sh = 24'd65536;

  logic [53:0]        point_q[$];
  logic signed [24:0] elev_q[$];
  int  src_gap = 0;
  int  snk_gap = 0;
  int  hold_left = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  bit  idle_on = 1;
  int  errors = 0;
  int  cycles = 0;

  fractal_value_noise_3d_core dut (.*);

  always #6 clk = ~clk;

  // Hash one lattice corner to a value in [-1,1], Q16
  function automatic longint corner_hash(logic [63:0] x, logic [63:0] y, logic [63:0] z,
                                         logic [63:0] s);
    logic [63:0] h;
    h = s ^ (x * AXIS_MUL[0]) ^ (y * AXIS_MUL[1]) ^ (z * AXIS_MUL[2]);
    h = h ^ (h >> 33);
    h = h * MIX_MUL[0];
    h = h ^ (h >> 33);
    h = h * MIX_MUL[1];
    h = h ^ (h >> 33);
    return longint'((64'(h[15:0]) * 64'd131072) / 64'd65535) - 65536;
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return a + (((b - a) * w) >>> 16);
  endfunction

  // Expected elevation for one point under the current registers
  function automatic logic signed [24:0] predict_elevation(logic [53:0] pt);
    longint p[3];
    longint w[3];
    logic [63:0] ix[3];
    longint cv[8];
    longint ab[4];
    longint c, noise, sum;
    logic [63:0] base, s, f, t, t2, t3, poly, rden, rnum, r;
    logic signed [127:0] wide, det, hs128, tenth;
    int n;
    for (int a = 0; a < 3; a++) p[a] = longint'($signed(pt[a*18 +: 18]));
    n = oct_sh;
    if (n < 1) n = 1;
    if (n > 8) n = 8;
    base = seed_sh ^ stream_sh;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      s = base ^ (64'(i + 1) * OCT_SALT);
      f = 64'(freq_sh) << (2 + i);
      for (int a = 0; a < 3; a++) begin
        c = p[a] * longint'(f);
        ix[a] = c >>> 32;
        t = {48'b0, c[31:16]};
        t2 = (t * t) >> 16;
        t3 = (t2 * t) >> 16;
        poly = 64'd6 * t2 + (64'd10 << 16) - 64'd15 * t;
        w[a] = longint'((t3 * poly) >> 16);
      end
      for (int k = 0; k < 8; k++)
        cv[k] = corner_hash(ix[0] + k[0], ix[1] + k[1], ix[2] + k[2], s);
      for (int j = 0; j < 4; j++) ab[j] = blend(cv[2*j], cv[2*j+1], w[0]);
      noise = blend(blend(ab[0], ab[1], w[1]), blend(ab[2], ab[3], w[1]), w[2]);
      sum += noise * (longint'(1) <<< (15 - i));
    end
    rden = (64'd1 << n) - 1;
    rnum = 64'd1 << (n + 29);
    r = (rnum + rden / 2) / rden;
    wide = $signed({{64{sum[63]}}, sum}) * $signed({64'b0, r});
    det = wide >>> 45;
    hs128 = $signed({104'b0, height_sh});
    tenth = 128'sd104858;
    wide = (det * hs128 * tenth) >>> 36;
    if (wide > 128'sd16777215) wide = 128'sd16777215;
    if (wide < -128'sd16777216) wide = -128'sd16777216;
    return wide[24:0];
  endfunction

  function automatic logic [17:0] rand_coord();
    if ($urandom_range(0, 99) < 85) return 18'($signed($urandom_range(0, 131072)) - 65536);
    return 18'($urandom);
  endfunction

  function automatic logic [53:0] mk_point(logic [17:0] x, logic [17:0] y, logic [17:0] z);
    return {z, y, x};
  endfunction

  // Source side: present queued points, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        elev_q.push_back(predict_elevation(s_tdata[53:0]));
        void'(point_q.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        // hold the request until taken
      end else if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (point_q.size() > 0) begin
        if (idle_on && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 6);
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b0, point_q[0]};
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: check results, drive backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (elev_q.size() == 0) begin
          $error("elevation_detail: unexpected result %0d", $signed(m_tdata[24:0]));
          errors++;
        end else begin
          logic signed [24:0] want;
          want = elev_q.pop_front();
          if (m_tdata[24:0] !== want) begin
            $error("elevation_detail: expected %0d, actual %0d", want,
                   $signed(m_tdata[24:0]));
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(0, 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("fractal_value_noise_3d_core regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SEED:   seed_sh = val;
      REG_STREAM: stream_sh = val;
      REG_FREQ:   freq_sh = val[23:0];
      REG_OCT:    oct_sh = val[3:0];
      REG_HEIGHT: height_sh = val[23:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [63:0] sd, logic [63:0] so, logic [63:0] fr,
                          logic [63:0] oc, logic [63:0] hs);
    write_reg(REG_SEED, sd);
    write_reg(REG_STREAM, so);
    write_reg(REG_FREQ, fr);
    write_reg(REG_OCT, oc);
    write_reg(REG_HEIGHT, hs);
  endtask

  // Pause the source until the pipe has drained
  task automatic drain();
    while (point_q.size() > 0 || elev_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++)
      point_q.push_back(mk_point(rand_coord(), rand_coord(), rand_coord()));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // Directed points at reset settings: axis extremes, raw patterns, fractions
    point_q.push_back(mk_point(18'd0, 18'd0, 18'd0));
    point_q.push_back(mk_point(18'd65536, 18'd0, 18'd0));
    point_q.push_back(mk_point(-18'sd65536, 18'd0, 18'd0));
    point_q.push_back(mk_point(18'd0, 18'd65536, 18'd0));
    point_q.push_back(mk_point(18'd0, -18'sd65536, 18'd0));
    point_q.push_back(mk_point(18'd0, 18'd0, 18'd65536));
    point_q.push_back(mk_point(18'd0, 18'd0, -18'sd65536));
    point_q.push_back(mk_point(18'd65536, 18'd65536, 18'd65536));
    point_q.push_back(mk_point(-18'sd65536, -18'sd65536, -18'sd65536));
    point_q.push_back(mk_point(18'h1FFFF, 18'h1FFFF, 18'h1FFFF));
    point_q.push_back(mk_point(18'h20000, 18'h20000, 18'h20000));
    point_q.push_back(mk_point(18'h3FFFF, 18'h3FFFF, 18'h3FFFF));
    point_q.push_back(mk_point(18'd1, 18'd1, 18'd1));
    point_q.push_back(mk_point(18'd32768, 18'd16384, 18'd49152));
    point_q.push_back(mk_point(18'h2AAAA, 18'h15555, 18'h2AAAA));
    point_q.push_back(mk_point(18'd12345, -18'sd23456, 18'd34567));
    drain();

    // Registers at their extremes, including out-of-range octave counts
    set_regs(ALL_ONES, 64'd0, 64'd0, 64'd0, 64'hFFFFFF);
    write_reg(REG_SPARE_LO, ALL_ONES);
    write_reg(REG_SPARE_HI, 64'd0);
    point_q.push_back(mk_point(18'd65536, -18'sd65536, 18'd777));
    queue_random(8);
    drain();
    set_regs(64'd0, ALL_ONES, ALL_ONES, 64'd15, ALL_ONES);
    point_q.push_back(mk_point(18'h1FFFF, 18'h20000, 18'd0));
    queue_random(60);
    drain();
    set_regs({$urandom, $urandom}, {$urandom, $urandom}, 64'd65536, 64'd1, 64'd0);
    queue_random(40);
    drain();
    set_regs({$urandom, $urandom}, {$urandom, $urandom}, 64'd1, 64'd8, 64'hFFFFFF);
    queue_random(40);
    drain();

    // Long sink stall while the source keeps offering points
    set_regs({$urandom, $urandom}, ALL_ONES, 64'd65536, 64'd4, 64'd65536);
    hold_req = 1;
    queue_random(220);
    drain();

    // Random register sets
    for (int ph = 0; ph < 6; ph++) begin
      set_regs({$urandom, $urandom}, {$urandom, $urandom},
               64'($urandom_range(0, 24'hFFFFFF)), 64'($urandom_range(0, 15)),
               64'($urandom_range(0, 24'hFFFFFF)));
      queue_random(70);
      drain();
    end

    // Closing phase with no idling
    idle_on = 0;
    set_regs({$urandom, $urandom}, {$urandom, $urandom}, 64'd300000, 64'd6, 64'd655360);
    queue_random(100);
    drain();

    if (errors == 0) begin
      $display("fractal_value_noise_3d_core regression: pass");
    end else begin
      $display("fractal_value_noise_3d_core regression: fail");
    end
    $finish;
  end

endmodule
